### hw/rtl/ohb_pkg.sv
package ohb_pkg;

  // Field widths
  localparam int unsigned HashW   = 32;
  localparam int unsigned BucketW = 10;
  localparam int unsigned CountW  = 11;
  localparam int unsigned KeyW    = 8;

  // Largest usable bucket count
  localparam logic [CountW-1:0] MaxBuckets = CountW'(1024);

  // Default depth of the queue between front and back
  localparam int unsigned QueueDepthDef = 4;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### hw/rtl/ohb_front.sv
module ohb_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [ohb_pkg::KeyW-1:0]   key_byte_i,
  input  logic                       last_byte_i,
  input  ohb_pkg::q_stat_t           q_stat_i,
  output logic                       q_push_o,
  output logic [ohb_pkg::HashW-1:0]  q_data_o
);

  logic [ohb_pkg::HashW-1:0] hash_q, hash_d;
  logic [ohb_pkg::HashW-1:0] sum;
  logic [ohb_pkg::HashW-1:0] mixed;
  logic                      accept;

  // Hold off every key byte while the queue has no room for a finished key
  assign full   = q_stat_i.full;
  assign accept = push && !full;

  // Per-byte mix: add byte, add <<10, xor >>6
  always_comb begin
    sum   = hash_q + {{(ohb_pkg::HashW-ohb_pkg::KeyW){1'b0}}, key_byte_i};
    sum   = sum + (sum << 10);
    mixed = sum ^ (sum >> 6);
  end

  // Running hash update; cleared after the last byte of a key
  always_comb begin
    hash_d = hash_q;
    if (accept) begin
      hash_d = last_byte_i ? '0 : mixed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

  // Mixed hash of a finished key goes to the back
  assign q_push_o = accept && last_byte_i;
  assign q_data_o = mixed;

endmodule

### hw/rtl/ohb_queue.sv
module ohb_queue #(
  parameter int unsigned Depth = ohb_pkg::QueueDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [ohb_pkg::HashW-1:0]  push_data_i,
  input  logic                       pop_i,
  output logic [ohb_pkg::HashW-1:0]  head_o,
  output ohb_pkg::q_stat_t           stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [ohb_pkg::HashW-1:0] mem_q [Depth];
  logic [PtrW-1:0]           wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]           cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Front never writes into a full queue, back never reads an empty one
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && stat_o.full && !pop_i))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && stat_o.empty))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

endmodule

### hw/rtl/ohb_back.sv
module ohb_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ohb_pkg::CountW-1:0]   bucket_count_i,
  input  ohb_pkg::q_stat_t             q_stat_i,
  input  logic [ohb_pkg::HashW-1:0]    q_head_i,
  output logic                         q_pop_o,
  output logic                         empty,
  input  logic                         pop,
  output logic [ohb_pkg::HashW-1:0]    hash_value_o,
  output logic [ohb_pkg::BucketW-1:0]  bucket_index_o
);

  localparam int unsigned BitW = $clog2(ohb_pkg::HashW);

  typedef enum logic [2:0] {
    StIdle,
    StFin1,
    StFin2,
    StFin3,
    StDiv,
    StWb
  } state_e;

  state_e                        state_q;
  logic                          out_valid_q;
  logic [ohb_pkg::HashW-1:0]     hash_q;
  logic [ohb_pkg::BucketW-1:0]   rem_q;
  logic [BitW-1:0]               bit_q;
  logic [ohb_pkg::HashW-1:0]     hash_out_q;
  logic [ohb_pkg::BucketW-1:0]   bucket_out_q;

  logic [ohb_pkg::CountW-1:0]    n_eff;
  logic [BitW-1:0]               bit_idx;
  logic [ohb_pkg::CountW-1:0]    rem_sh;
  logic [ohb_pkg::CountW-1:0]    rem_sub;
  logic [ohb_pkg::BucketW-1:0]   rem_nx;

  // Bucket count clamped to 1..1024
  always_comb begin
    if (bucket_count_i == '0) begin
      n_eff = ohb_pkg::CountW'(1);
    end else if (bucket_count_i > ohb_pkg::MaxBuckets) begin
      n_eff = ohb_pkg::MaxBuckets;
    end else begin
      n_eff = bucket_count_i;
    end
  end

  // One restoring remainder step per cycle, hash MSB first
  always_comb begin
    bit_idx = BitW'(ohb_pkg::HashW - 1) - bit_q;
    rem_sh  = {rem_q, hash_q[bit_idx]};
    rem_sub = rem_sh - n_eff;
    rem_nx  = (rem_sh >= n_eff) ? rem_sub[ohb_pkg::BucketW-1:0]
                                : rem_sh[ohb_pkg::BucketW-1:0];
  end

  assign q_pop_o        = (state_q == StIdle) && !q_stat_i.empty;
  assign empty          = !out_valid_q;
  assign hash_value_o   = hash_out_q;
  assign bucket_index_o = bucket_out_q;

  // Sequencer: finalize steps StFin1, StFin2 and StFin3, then bit-serial modulo, then writeback
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      out_valid_q  <= 1'b0;
      hash_q       <= '0;
      rem_q        <= '0;
      bit_q        <= '0;
      hash_out_q   <= '0;
      bucket_out_q <= '0;
    end else begin
      // Writeback below refills the slot in the same cycle it is popped
      if (pop && out_valid_q && (state_q != StWb)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (!q_stat_i.empty) begin
            hash_q  <= q_head_i;
            state_q <= StFin1;
          end
        end
        StFin1: begin
          hash_q  <= hash_q + (hash_q << 3);
          state_q <= StFin2;
        end
        StFin2: begin
          hash_q  <= hash_q ^ (hash_q >> 11);
          state_q <= StFin3;
        end
        StFin3: begin
          hash_q  <= hash_q + (hash_q << 15);
          rem_q   <= '0;
          bit_q   <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          rem_q <= rem_nx;
          bit_q <= bit_q + BitW'(1);
          if (bit_q == BitW'(ohb_pkg::HashW - 1)) begin
            state_q <= StWb;
          end
        end
        StWb: begin
          // Wait for the result slot to free up
          if (!out_valid_q || pop) begin
            hash_out_q   <= hash_q;
            bucket_out_q <= rem_q;
            out_valid_q  <= 1'b1;
            state_q      <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // A waiting result always lies inside the configured bucket range
  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ({1'b0, bucket_out_q} < n_eff))
    else $error("bucket index out of range");

  // Remainder stays below the divisor throughout the modulo
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> ({1'b0, rem_q} < n_eff))
    else $error("partial remainder out of range");

  // A key pulled from the queue always starts the finalize sequence
  a_pop_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == StFin1))
    else $error("queue pop did not start finalize");

endmodule

### hw/rtl/one_at_a_time_hash_bucket.sv
// One-at-a-time hash with bucket reduction. Key bytes are pushed one per
// cycle; full holds off all bytes while the queue is full. last_byte_i marks
// the end of a key; each byte is mixed into the running hash in the cycle it
// is accepted. A finished key moves into a queue of QueueDepth entries; the
// back end takes it through 1 queue pull, 3 finalize steps, 32 bit-serial
// remainder steps and 1 writeback, waiting in writeback while the previous
// result is not yet popped, before the hash and bucket index show up at the
// result side. It pulls a new key only after writing back the last one, so
// the serial remainder unit limits the key rate; the queue absorbs bursts of
// up to QueueDepth short keys. bucket_count is clamped to 1..1024 and should
// only be written while the block is idle.
module one_at_a_time_hash_bucket #(
  parameter int unsigned QueueDepth = ohb_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ohb_pkg::CountW-1:0]   cfg_wdata_i,
  input  logic                         push,
  output logic                         full,
  input  logic [ohb_pkg::KeyW-1:0]     key_byte_i,
  input  logic                         last_byte_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [ohb_pkg::HashW-1:0]    hash_value_o,
  output logic [ohb_pkg::BucketW-1:0]  bucket_index_o
);

  logic [ohb_pkg::CountW-1:0] bucket_count_q;
  ohb_pkg::q_stat_t           q_stat;
  logic                       q_push;
  logic [ohb_pkg::HashW-1:0]  q_wdata;
  logic                       q_pop;
  logic [ohb_pkg::HashW-1:0]  q_head;

  // Bucket count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= ohb_pkg::CountW'(1);
    end else if (cfg_we_i) begin
      bucket_count_q <= cfg_wdata_i;
    end
  end

  ohb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .key_byte_i  (key_byte_i),
    .last_byte_i (last_byte_i),
    .q_stat_i    (q_stat),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  ohb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .stat_o      (q_stat)
  );

  ohb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .bucket_count_i (bucket_count_q),
    .q_stat_i       (q_stat),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .hash_value_o   (hash_value_o),
    .bucket_index_o (bucket_index_o)
  );

endmodule
